FILE: rtl/core/spqc_pkg.sv
`timescale 1ns / 1ps

package spqc_pkg;

  localparam int QUEUE_DEPTH  = 32;
  localparam int SIGNAL_COUNT = 64;
  localparam int RT_FIRST     = 32;
  localparam int KILL_SIGNAL  = 9;
  localparam int STOP_SIGNAL  = 19;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  // Standard signals that a dequeue may pick: 1 up to one below the real-time base.
  localparam int STD_N = ((RT_FIRST < SIGNAL_COUNT) ? RT_FIRST : SIGNAL_COUNT) - 1;

  localparam logic [63:0] UNBLOCKABLE =
      (64'd1 << (KILL_SIGNAL - 1)) | (64'd1 << (STOP_SIGNAL - 1));

  typedef enum logic [2:0] {
    CMD_SEND    = 3'd0,
    CMD_DEQUEUE = 3'd1,
    CMD_BLOCK   = 3'd2,
    CMD_UNBLOCK = 3'd3,
    CMD_SETMASK = 3'd4,
    CMD_FLUSH   = 3'd5,
    CMD_QUERY   = 3'd6,
    CMD_BAD     = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_FULL    = 3'd2,
    ST_NONE    = 3'd3,
    ST_BADCMD  = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [6:0]         sig;
    logic signed [7:0]  info_code;
    logic [31:0]        sender_pid;
    logic [31:0]        sender_uid;
    logic signed [31:0] info_status;
    logic [63:0]        mask_in;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [6:0]         out_sig;
    logic signed [7:0]  out_code;
    logic [31:0]        out_pid;
    logic [31:0]        out_uid;
    logic signed [31:0] out_status;
    logic               has_pending;
    logic [63:0]        pending_mask;
    logic [63:0]        blocked_mask;
  } rsp_t;

  // One queued real-time record.
  typedef struct packed {
    logic [6:0]         sig;
    logic signed [7:0]  code;
    logic [31:0]        pid;
    logic [31:0]        uid;
    logic signed [31:0] status;
  } rec_t;

  typedef struct packed {
    logic capture;
    logic append;
    logic remove;
  } cell_ctl_t;

endpackage

FILE: rtl/core/spqc_cell.sv
`timescale 1ns / 1ps

module spqc_cell (
  input  logic                     clk,
  input  logic [spqc_pkg::CNT_W-1:0] idx,
  input  logic [spqc_pkg::CNT_W-1:0] count,
  input  logic [63:0]              blocked,
  input  spqc_pkg::cell_ctl_t      ctl,
  input  spqc_pkg::rec_t           new_rec,
  input  spqc_pkg::rec_t           next_rec,
  input  logic                     hit_in,
  input  spqc_pkg::rec_t           sel_in,
  output spqc_pkg::rec_t           rec_out,
  output logic                     hit_out,
  output spqc_pkg::rec_t           sel_out
);
  import spqc_pkg::*;

  rec_t       rec;
  logic       match;
  logic [5:0] bidx;
  logic       first_here;

  assign bidx       = 6'(rec.sig - 7'd1);
  assign first_here = match && !hit_in;
  assign hit_out    = hit_in || match;
  assign sel_out    = first_here ? rec : sel_in;
  assign rec_out    = rec;

  // The match bit is taken when a word is accepted; the state it looks at
  // does not change until that word executes.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      match <= (idx < count) && !blocked[bidx];
    end
    if (ctl.append && idx == count) begin
      rec <= new_rec;
    end else if (ctl.remove && hit_out) begin
      rec <= next_rec;
    end
  end

endmodule

FILE: rtl/core/signal_pending_queue_controller.sv
`timescale 1ns / 1ps

// Pending-signal controller with a queue of real-time records held in a row
// of QUEUE_DEPTH cells. Each command word has an accept cycle and an execute
// cycle: the accept cycle registers the word and lets every cell flag whether
// its record is live and unblocked, and the execute cycle resolves the oldest
// flagged cell along the cell chain, appends a record or shifts the younger
// records up by one, updates the masks and loads the response register. A new
// word is accepted once the previous one has executed; execution waits while
// an earlier response is still held. There is no clearing pass after reset.
module signal_pending_queue_controller (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  spqc_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output spqc_pkg::rsp_t  rsp
);
  import spqc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t           state;
  req_t             req_q;
  logic [63:0]      pending;
  logic [63:0]      blocked;
  logic [CNT_W-1:0] count;
  logic [STD_N-1:0] std_hit;

  logic [63:0]      pending_next;
  logic [63:0]      blocked_next;
  logic [CNT_W-1:0] count_next;
  rsp_t             rsp_next;
  logic             accept;
  logic             exec;
  logic             do_append;
  logic             do_remove;
  cell_ctl_t        ctl;
  rec_t             new_rec;
  logic [STD_N-1:0] std_ready;
  logic [STD_N-1:0] std_low;
  logic [6:0]       std_sig;
  logic [5:0]       sbit;
  logic [5:0]       qbit;

  rec_t             recs [QUEUE_DEPTH];
  rec_t             sel  [QUEUE_DEPTH+1];
  logic [QUEUE_DEPTH:0] hit;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign exec      = (state == S_EXEC) && (!rsp_valid || rsp_ready);

  assign ctl.capture = accept;
  assign ctl.append  = exec && do_append;
  assign ctl.remove  = exec && do_remove;

  assign new_rec.sig    = req_q.sig;
  assign new_rec.code   = req_q.info_code;
  assign new_rec.pid    = req_q.sender_pid;
  assign new_rec.uid    = req_q.sender_uid;
  assign new_rec.status = req_q.info_status;

  assign hit[0] = 1'b0;
  assign sel[0] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    rec_t nb;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nb = '0;
    end else begin : g_mid
      assign nb = recs[i+1];
    end
    spqc_cell u_cell (
      .clk      (clk),
      .idx      (CNT_W'(i)),
      .count    (count),
      .blocked  (blocked),
      .ctl      (ctl),
      .new_rec  (new_rec),
      .next_rec (nb),
      .hit_in   (hit[i]),
      .sel_in   (sel[i]),
      .rec_out  (recs[i]),
      .hit_out  (hit[i+1]),
      .sel_out  (sel[i+1])
    );
  end

  // Lowest ready standard signal, isolated as a one-hot at accept time.
  assign std_ready = pending[STD_N-1:0] & ~blocked[STD_N-1:0];
  assign std_low   = std_ready & (~std_ready + STD_N'(1));

  always_comb begin
    std_sig = '0;
    for (int i = 0; i < STD_N; i++) begin
      if (std_hit[i]) begin
        std_sig = std_sig | 7'(i + 1);
      end
    end
  end

  assign sbit = 6'(req_q.sig - 7'd1);
  assign qbit = 6'(sel[QUEUE_DEPTH].sig - 7'd1);

  always_comb begin
    pending_next = pending;
    blocked_next = blocked;
    count_next   = count;
    do_append    = 1'b0;
    do_remove    = 1'b0;
    rsp_next     = '0;
    rsp_next.status = ST_OK;
    case (cmd_t'(req_q.cmd))
      CMD_SEND: begin
        if (req_q.sig == 7'd0 || 32'(req_q.sig) >= SIGNAL_COUNT) begin
          rsp_next.status = ST_INVALID;
        end else if (32'(req_q.sig) < RT_FIRST) begin
          pending_next[sbit] = 1'b1;
        end else if (32'(count) >= QUEUE_DEPTH) begin
          rsp_next.status = ST_FULL;
        end else begin
          do_append          = 1'b1;
          count_next         = count + CNT_W'(1);
          pending_next[sbit] = 1'b1;
        end
      end
      CMD_DEQUEUE: begin
        if ((pending & ~blocked) == 64'd0) begin
          rsp_next.status = ST_NONE;
        end else if (hit[QUEUE_DEPTH]) begin
          do_remove           = 1'b1;
          count_next          = count - CNT_W'(1);
          pending_next[qbit]  = 1'b0;
          rsp_next.out_sig    = sel[QUEUE_DEPTH].sig;
          rsp_next.out_code   = sel[QUEUE_DEPTH].code;
          rsp_next.out_pid    = sel[QUEUE_DEPTH].pid;
          rsp_next.out_uid    = sel[QUEUE_DEPTH].uid;
          rsp_next.out_status = sel[QUEUE_DEPTH].status;
        end else if (std_hit != '0) begin
          pending_next[STD_N-1:0] = pending[STD_N-1:0] & ~std_hit;
          rsp_next.out_sig        = std_sig;
        end else begin
          rsp_next.status = ST_NONE;
        end
      end
      CMD_BLOCK:   blocked_next = (blocked | req_q.mask_in) & ~UNBLOCKABLE;
      CMD_UNBLOCK: blocked_next = (blocked & ~req_q.mask_in) & ~UNBLOCKABLE;
      CMD_SETMASK: blocked_next = req_q.mask_in & ~UNBLOCKABLE;
      CMD_FLUSH: begin
        pending_next = '0;
        count_next   = '0;
      end
      CMD_QUERY: ;
      default: rsp_next.status = ST_BADCMD;
    endcase
    rsp_next.has_pending  = (pending_next & ~blocked_next) != 64'd0;
    rsp_next.pending_mask = pending_next;
    rsp_next.blocked_mask = blocked;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pending   <= '0;
      blocked   <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (exec) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (exec) begin
            state   <= S_IDLE;
            pending <= pending_next;
            blocked <= blocked_next;
            count   <= count_next;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q   <= req;
      std_hit <= std_low;
    end
    if (exec) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= QUEUE_DEPTH)
    else $error("queue count exceeds depth");

  a_unblockable: assert property (@(posedge clk) disable iff (rst)
    (blocked & UNBLOCKABLE) == 64'd0)
    else $error("kill or stop signal is blocked");

  a_has_pending: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.has_pending == ((rsp.pending_mask & ~blocked) != 64'd0))
    else $error("held response disagrees with mask state");

  a_idle_out_sig: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.out_sig == 7'd0)
    else $error("signal reported on a failed word");
`endif

endmodule

FILE: bench/tb_signal_pending_queue_controller.sv
`timescale 1ns / 1ps

module tb_signal_pending_queue_controller;
  import spqc_pkg::*;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  signal_pending_queue_controller dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block's state, advanced once per accepted word.
  logic [63:0] sim_pending = '0;
  logic [63:0] sim_blocked = '0;
  rec_t        sim_recs[$];

  rsp_t        want_rsp_q[$];
  int          err_count = 0;
  int          tx_idle_pct = 14;
  int          rx_idle_pct = 53;
  bit          hold_off_req = 1'b0;

  typedef struct {
    req_t w;
    bit   typed;
    rsp_t want;
  } dir_row_t;

  dir_row_t dir_tab[$];

  function automatic logic [63:0] sig_mask(input int unsigned s);
    if (s < 1 || s > 64) return '0;
    return 64'd1 << (s - 1);
  endfunction

  function automatic rsp_t next_response(input req_t w);
    rsp_t        r;
    rec_t        entry;
    logic [63:0] ready_set;
    logic [63:0] locked;
    bit          found;
    int          k;
    r = '0;
    r.status = ST_OK;
    r.blocked_mask = sim_blocked;
    found = 1'b0;
    locked = sig_mask(KILL_SIGNAL) | sig_mask(STOP_SIGNAL);
    case (w.cmd)
      CMD_SEND: begin
        if (w.sig == 0 || w.sig >= SIGNAL_COUNT) begin
          r.status = ST_INVALID;
        end else if (w.sig < RT_FIRST) begin
          sim_pending |= sig_mask(w.sig);
        end else if (sim_recs.size() >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          entry.sig = w.sig;
          entry.code = w.info_code;
          entry.pid = w.sender_pid;
          entry.uid = w.sender_uid;
          entry.status = w.info_status;
          sim_recs.push_back(entry);
          sim_pending |= sig_mask(w.sig);
        end
      end
      CMD_DEQUEUE: begin
        if ((sim_pending & ~sim_blocked) != 0) begin
          // Oldest unblocked record wins, even if its pending bit is already clear.
          for (k = 0; k < sim_recs.size() && !found; k++) begin
            if ((sim_blocked & sig_mask(sim_recs[k].sig)) == 0) begin
              r.out_sig = sim_recs[k].sig;
              r.out_code = sim_recs[k].code;
              r.out_pid = sim_recs[k].pid;
              r.out_uid = sim_recs[k].uid;
              r.out_status = sim_recs[k].status;
              sim_pending &= ~sig_mask(sim_recs[k].sig);
              sim_recs.delete(k);
              found = 1'b1;
            end
          end
          ready_set = sim_pending & ~sim_blocked;
          for (k = 1; k < RT_FIRST && k < SIGNAL_COUNT && !found; k++) begin
            if ((ready_set & sig_mask(k)) != 0) begin
              r.out_sig = 7'(k);
              sim_pending &= ~sig_mask(k);
              found = 1'b1;
            end
          end
        end
        if (!found) r.status = ST_NONE;
      end
      CMD_BLOCK:   sim_blocked = (sim_blocked | w.mask_in) & ~locked;
      CMD_UNBLOCK: sim_blocked = sim_blocked & ~w.mask_in & ~locked;
      CMD_SETMASK: sim_blocked = w.mask_in & ~locked;
      CMD_FLUSH: begin
        sim_pending = '0;
        sim_recs.delete();
      end
      CMD_QUERY: ;
      default:   r.status = ST_BADCMD;
    endcase
    r.has_pending = (sim_pending & ~sim_blocked) != 0;
    r.pending_mask = sim_pending;
    return r;
  endfunction

  function automatic req_t mk_req(input cmd_t c, input logic [6:0] s, input logic [7:0] code,
                                  input logic [31:0] pid, input logic [31:0] uid,
                                  input logic [31:0] st, input logic [63:0] m);
    req_t w;
    w.cmd = c;
    w.sig = s;
    w.info_code = code;
    w.sender_pid = pid;
    w.sender_uid = uid;
    w.info_status = st;
    w.mask_in = m;
    return w;
  endfunction

  function automatic rsp_t mk_exp(input status_t st, input bit hp, input logic [63:0] pend,
                                  input logic [63:0] blk);
    rsp_t r;
    r = '0;
    r.status = st;
    r.has_pending = hp;
    r.pending_mask = pend;
    r.blocked_mask = blk;
    return r;
  endfunction

  task automatic add_row(input req_t w, input bit typed, input rsp_t want);
    dir_row_t row;
    row.w = w;
    row.typed = typed;
    row.want = want;
    dir_tab.push_back(row);
  endtask

  // Fill episodes lean on real-time sends so the record queue reaches full;
  // drain episodes lean on dequeues.
  function automatic req_t rand_word(input bit drain);
    req_t        w;
    int unsigned roll;
    int unsigned roll2;
    int unsigned t_rt;
    int unsigned t_std;
    int unsigned t_deq;
    logic [63:0] sparse;
    roll = $urandom_range(99);
    roll2 = $urandom_range(99);
    t_rt = drain ? 12 : 66;
    t_std = t_rt + (drain ? 10 : 10);
    t_deq = t_std + (drain ? 55 : 12);
    sparse = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
    w.cmd = CMD_SEND;
    w.sig = 7'($urandom_range(RT_FIRST, SIGNAL_COUNT - 1));
    w.info_code = 8'($urandom);
    w.sender_pid = $urandom;
    w.sender_uid = $urandom;
    w.info_status = $urandom;
    w.mask_in = sparse;
    if (roll < t_rt) begin
      w.cmd = CMD_SEND;
    end else if (roll < t_std) begin
      w.sig = 7'($urandom_range(1, RT_FIRST - 1));
    end else if (roll < t_deq) begin
      w.cmd = CMD_DEQUEUE;
    end else if (roll2 < 25) begin
      w.cmd = CMD_BLOCK;
    end else if (roll2 < 45) begin
      w.cmd = CMD_UNBLOCK;
      w.mask_in = {$urandom, $urandom};
    end else if (roll2 < 65) begin
      w.cmd = CMD_SETMASK;
    end else if (roll2 < 75) begin
      w.cmd = CMD_QUERY;
    end else if (roll2 < 83) begin
      w.cmd = CMD_BAD;
      w.mask_in = {$urandom, $urandom};
    end else if (roll2 < 95) begin
      w.sig = $urandom_range(1) ? 7'd0 : 7'($urandom_range(SIGNAL_COUNT, 127));
    end else begin
      w.cmd = CMD_FLUSH;
    end
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer(input req_t w, input bit typed, input rsp_t fixed);
    rsp_t pred;
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    pred = next_response(w);
    want_rsp_q.push_back(typed ? fixed : pred);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic cmp(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", name, want, got);
      err_count++;
    end
  endtask

  rsp_t want;

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (want_rsp_q.size() == 0) begin
        $error("response word with nothing outstanding");
        err_count++;
      end else begin
        want = want_rsp_q.pop_front();
        cmp("status", want.status, rsp.status);
        cmp("out_sig", want.out_sig, rsp.out_sig);
        cmp("out_code", want.out_code, rsp.out_code);
        cmp("out_pid", want.out_pid, rsp.out_pid);
        cmp("out_uid", want.out_uid, rsp.out_uid);
        cmp("out_status", want.out_status, rsp.out_status);
        cmp("has_pending", want.has_pending, rsp.has_pending);
        cmp("pending_mask", want.pending_mask, rsp.pending_mask);
        cmp("blocked_mask", want.blocked_mask, rsp.blocked_mask);
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off when asked.
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_ready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #2000000;
    $display("tb_signal_pending_queue_controller: done, errors");
    $finish;
  end

  initial begin
    rsp_t none;
    int   n;
    int   ph;
    int   i;
    none = '0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;

    add_row(mk_req(CMD_QUERY, 0, 0, 0, 0, 0, 0), 1, mk_exp(ST_OK, 0, 0, 0));
    add_row(mk_req(CMD_DEQUEUE, 0, 0, 0, 0, 0, 0), 1, mk_exp(ST_NONE, 0, 0, 0));
    add_row(mk_req(CMD_SEND, 0, 8'h5a, 32'h1234, 32'h5678, 32'h9abc, 0), 1,
            mk_exp(ST_INVALID, 0, 0, 0));
    add_row(mk_req(CMD_SEND, 64, '1, '1, '1, '1, '1), 1, mk_exp(ST_INVALID, 0, 0, 0));
    add_row(mk_req(CMD_SEND, 127, '1, '1, '1, '1, '1), 1, mk_exp(ST_INVALID, 0, 0, 0));
    add_row(mk_req(CMD_BAD, '1, '1, '1, '1, '1, '1), 1, mk_exp(ST_BADCMD, 0, 0, 0));
    add_row(mk_req(CMD_SEND, 1, 0, 0, 0, 0, 0), 1, mk_exp(ST_OK, 1, 64'h1, 0));
    add_row(mk_req(CMD_SEND, 63, 8'h80, '1, 0, 32'h8000_0000, 0), 0, none);
    add_row(mk_req(CMD_SEND, 32, 8'h7f, 0, '1, 32'h7fff_ffff, '1), 0, none);
    add_row(mk_req(CMD_SETMASK, 0, 0, 0, 0, 0, '1), 0, none);
    add_row(mk_req(CMD_DEQUEUE, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk_req(CMD_SEND, 7'(KILL_SIGNAL), 0, 0, 0, 0, 0), 0, none);
    add_row(mk_req(CMD_SEND, 7'(STOP_SIGNAL), 0, 0, 0, 0, 0), 0, none);
    add_row(mk_req(CMD_DEQUEUE, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk_req(CMD_UNBLOCK, 0, 0, 0, 0, 0, 64'h4000_0000_0000_0000), 0, none);
    add_row(mk_req(CMD_DEQUEUE, 0, 0, 0, 0, 0, 0), 0, none);
    // Two records of one signal: the second is still delivered after the
    // first dequeue has cleared the pending bit.
    add_row(mk_req(CMD_SEND, 63, 8'h11, 32'haaaa, 32'hbbbb, 32'hcccc, 0), 0, none);
    add_row(mk_req(CMD_SEND, 63, 8'hee, 32'h5555, 32'h4444, 32'h3333, 0), 0, none);
    add_row(mk_req(CMD_DEQUEUE, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk_req(CMD_DEQUEUE, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk_req(CMD_DEQUEUE, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk_req(CMD_BLOCK, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk_req(CMD_UNBLOCK, 0, 0, 0, 0, 0, '1), 0, none);
    add_row(mk_req(CMD_FLUSH, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(mk_req(CMD_QUERY, 0, 0, 0, 0, 0, 0), 0, none);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (n = 0; n < dir_tab.size(); n++) begin
      offer(dir_tab[n].w, dir_tab[n].typed, dir_tab[n].want);
      idle_gap();
    end

    for (ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        tx_idle_pct = 53;
        rx_idle_pct = 14;
      end else if (ph == 2) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      // The long receiver stall lets the sender run into a full pipeline.
      if (ph != 1) hold_off_req = 1'b1;
      for (i = 0; i < 217; i++) begin
        offer(rand_word(((i / 80) % 2) == 1), 0, none);
        idle_gap();
      end
    end
    req_valid <= 1'b0;

    while (want_rsp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_signal_pending_queue_controller: done, clean");
    end else begin
      $display("tb_signal_pending_queue_controller: done, errors");
    end
    $finish;
  end

endmodule
